### hdl/tfl_pkg.sv
// ----------------------------------------------------------------------------
// tfl_pkg
// Shared widths, codes and controller/datapath signal groups for the
// fully associative translation buffer.
// ----------------------------------------------------------------------------
package tfl_pkg;

  localparam int TLB_DEPTH_DEFAULT = 16;

  localparam int PID_W   = 16;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int MAXE_W  = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_LRU  = 1'd1;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 5'd16;

  typedef struct packed {
    logic load_req;
    logic capture;
    logic select;
    logic drop_oldest;
    logic append;
    logic finish;
  } tfl_cmd_t;

  typedef struct packed {
    logic req_insert;
    logic evict_needed;
    logic cache_off;
    logic out_free;
  } tfl_stat_t;

endpackage

### hdl/tfl_if.sv
// ----------------------------------------------------------------------------
// tfl_req_if / tfl_rsp_if
// Valid/ready channels carrying one request and one response.
// ----------------------------------------------------------------------------
interface tfl_req_if;
  import tfl_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [PID_W-1:0]   pid;
  logic [PAGE_W-1:0]  page;
  logic [FRAME_W-1:0] frame;

  modport source (output valid, output cmd, output pid, output page, output frame,
                  input ready);
  modport sink   (input valid, input cmd, input pid, input page, input frame,
                  output ready);
endinterface

interface tfl_rsp_if;
  import tfl_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [FRAME_W-1:0] hit_frame;

  modport source (output valid, output hit, output hit_frame, input ready);
  modport sink   (input valid, input hit, input hit_frame, output ready);
endinterface

### hdl/tfl_ctrl.sv
// ----------------------------------------------------------------------------
// tfl_ctrl
// Sequencer for one request at a time: match, select and respond for a
// lookup; evict and append for an insert.
// ----------------------------------------------------------------------------
module tfl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tfl_pkg::tfl_stat_t stat,
  output tfl_pkg::tfl_cmd_t  cmd
);
  import tfl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MATCH  = 5'b00010,
    S_SELECT = 5'b00100,
    S_EVICT  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.capture = 1'b1;
        state_nxt   = stat.req_insert ? S_EVICT : S_SELECT;
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_EVICT: begin
        if (stat.cache_off) begin
          state_nxt = S_RESULT;
        end else if (stat.evict_needed) begin
          cmd.drop_oldest = 1'b1;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/tfl_dp.sv
// ----------------------------------------------------------------------------
// tfl_dp
// Entry list held in a shifting register row, with parallel tag compare,
// first-match selection, eviction, append and move-to-newest, plus the
// response register.
// ----------------------------------------------------------------------------
module tfl_dp #(
  parameter int DEPTH = tfl_pkg::TLB_DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tfl_pkg::tfl_cmd_t           cmd,
  output tfl_pkg::tfl_stat_t          stat,
  input  logic [CNT_W-1:0]            limit,
  input  logic                        policy_lru,
  input  logic                        in_cmd,
  input  logic [tfl_pkg::PID_W-1:0]   in_pid,
  input  logic [tfl_pkg::PAGE_W-1:0]  in_page,
  input  logic [tfl_pkg::FRAME_W-1:0] in_frame,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [tfl_pkg::FRAME_W-1:0] out_hit_frame
);
  import tfl_pkg::*;

  logic               req_cmd_r;
  logic [PID_W-1:0]   req_pid_r;
  logic [PAGE_W-1:0]  req_page_r;
  logic [FRAME_W-1:0] req_frame_r;

  logic [PID_W-1:0]   ent_pid_r   [DEPTH];
  logic [PAGE_W-1:0]  ent_page_r  [DEPTH];
  logic [FRAME_W-1:0] ent_frame_r [DEPTH];
  logic [PID_W-1:0]   ent_pid_nxt   [DEPTH];
  logic [PAGE_W-1:0]  ent_page_nxt  [DEPTH];
  logic [FRAME_W-1:0] ent_frame_nxt [DEPTH];

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DEPTH-1:0]   match_r, match_nxt;
  logic [DEPTH-1:0]   first_r, first_nxt;
  logic               hit_r;
  logic [DEPTH-1:0]   mv_mask;
  logic [FRAME_W-1:0] sel_frame;
  logic [CNT_W-1:0]   last_idx;
  logic               lru_move;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r;
  logic [FRAME_W-1:0] out_frame_r;

  assign stat.req_insert   = (req_cmd_r == CMD_INSERT);
  assign stat.evict_needed = (cnt_r >= limit);
  assign stat.cache_off    = (limit == '0);
  assign stat.out_free     = !out_valid_r || out_ready;

  assign last_idx  = cnt_r - CNT_W'(1);
  assign lru_move  = cmd.finish && (req_cmd_r == CMD_LOOKUP) && hit_r && policy_lru;
  assign first_nxt = match_r & (~match_r + DEPTH'(1));
  assign mv_mask   = ~(first_r - DEPTH'(1));

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      match_nxt[j] = !stat.cache_off && (CNT_W'(j) < cnt_r) &&
                     (ent_pid_r[j] == req_pid_r) && (ent_page_r[j] == req_page_r);
    end
  end

  always_comb begin
    sel_frame = '0;
    for (int j = 0; j < DEPTH; j++) begin
      sel_frame = sel_frame | (first_r[j] ? ent_frame_r[j] : '0);
    end
  end

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      ent_pid_nxt[j]   = ent_pid_r[j];
      ent_page_nxt[j]  = ent_page_r[j];
      ent_frame_nxt[j] = ent_frame_r[j];
      if (cmd.drop_oldest) begin
        ent_pid_nxt[j]   = ent_pid_r[(j < DEPTH - 1) ? j + 1 : j];
        ent_page_nxt[j]  = ent_page_r[(j < DEPTH - 1) ? j + 1 : j];
        ent_frame_nxt[j] = ent_frame_r[(j < DEPTH - 1) ? j + 1 : j];
      end else if (cmd.append && (CNT_W'(j) == cnt_r)) begin
        ent_pid_nxt[j]   = req_pid_r;
        ent_page_nxt[j]  = req_page_r;
        ent_frame_nxt[j] = req_frame_r;
      end else if (lru_move) begin
        if (CNT_W'(j) == last_idx) begin
          ent_pid_nxt[j]   = req_pid_r;
          ent_page_nxt[j]  = req_page_r;
          ent_frame_nxt[j] = sel_frame;
        end else if (mv_mask[j] && (CNT_W'(j) < last_idx)) begin
          ent_pid_nxt[j]   = ent_pid_r[(j < DEPTH - 1) ? j + 1 : j];
          ent_page_nxt[j]  = ent_page_r[(j < DEPTH - 1) ? j + 1 : j];
          ent_frame_nxt[j] = ent_frame_r[(j < DEPTH - 1) ? j + 1 : j];
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.drop_oldest) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (cmd.append) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      ent_pid_r[j]   <= ent_pid_nxt[j];
      ent_page_r[j]  <= ent_page_nxt[j];
      ent_frame_r[j] <= ent_frame_nxt[j];
    end
    if (cmd.load_req) begin
      req_cmd_r   <= in_cmd;
      req_pid_r   <= in_pid;
      req_page_r  <= in_page;
      req_frame_r <= in_frame;
    end
    if (cmd.capture) begin
      match_r <= match_nxt;
    end
    if (cmd.select) begin
      first_r <= first_nxt;
      hit_r   <= |match_r;
    end
    if (cmd.finish) begin
      out_hit_r   <= (req_cmd_r == CMD_LOOKUP) && hit_r;
      out_frame_r <= ((req_cmd_r == CMD_LOOKUP) && hit_r) ? sel_frame : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_frame = out_frame_r;

endmodule

### hdl/tlb_fifo_lru_lookup.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_lookup
// Fully associative translation buffer with FIFO or LRU replacement.
//
//   channel  | direction | carries
//   ---------+-----------+-------------------------------------------
//   in_req   | in        | cmd, pid, page, frame
//   out_rsp  | out       | hit, hit_frame
//   cfg_*    | in        | write enable, register index, write data
//
// A lookup steps the sequencer through request capture, tag match, first-match
// select and response, which loads the response register once it is free. An
// insert drops the oldest entry until there is room, then appends the new one.
// Reset is synchronous, clears the entry count and restores the configuration.
// A request is accepted while an earlier response still waits; the response
// register holds it until the consumer takes it, and the sequencer waits.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_lookup #(
  parameter int TLB_DEPTH = tfl_pkg::TLB_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tfl_req_if.sink                        in_req,
  tfl_rsp_if.source                      out_rsp,
  input  logic                           cfg_we,
  input  logic [tfl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tfl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tfl_pkg::*;

  localparam int CNT_W = $clog2(TLB_DEPTH + 1);

  logic [MAXE_W-1:0] max_entries_r, max_entries_nxt;
  logic              policy_lru_r, policy_lru_nxt;
  logic [CNT_W-1:0]  limit;
  tfl_cmd_t          cmd;
  tfl_stat_t         stat;

  always_comb begin
    max_entries_nxt = max_entries_r;
    policy_lru_nxt  = policy_lru_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_ENTRIES: max_entries_nxt = cfg_wdata[MAXE_W-1:0];
        CFG_POLICY_LRU:  policy_lru_nxt  = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RESET;
      policy_lru_r  <= 1'b0;
    end else begin
      max_entries_r <= max_entries_nxt;
      policy_lru_r  <= policy_lru_nxt;
    end
  end

  always_comb begin
    if (32'(max_entries_r) > 32'(TLB_DEPTH)) begin
      limit = CNT_W'(TLB_DEPTH);
    end else begin
      limit = CNT_W'(max_entries_r);
    end
  end

  tfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tfl_dp #(
    .DEPTH (TLB_DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .limit         (limit),
    .policy_lru    (policy_lru_r),
    .in_cmd        (in_req.cmd),
    .in_pid        (in_req.pid),
    .in_page       (in_req.page),
    .in_frame      (in_req.frame),
    .out_valid     (out_rsp.valid),
    .out_ready     (out_rsp.ready),
    .out_hit       (out_rsp.hit),
    .out_hit_frame (out_rsp.hit_frame)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the translation buffer. A short table of requests
// covers the field extremes, duplicate tags, a lowered and a disabled limit
// and both replacement orders. Random phases with varied settings follow.
// Each response is compared with the table's value or an in-bench model.
// ----------------------------------------------------------------------------
module tb;
  import tfl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = TLB_DEPTH_DEFAULT;
  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT = 36;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 24;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAG_POOL = 20;
  localparam int PHASES = 8;
  localparam int PHASE_REQS = 210;
  localparam int STEADY_FROM = 600;
  localparam int STEADY_TO = 850;
  localparam int HOLD_AT = 1000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIRECTED = 24;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic               cmd;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_rsp_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  cmd;
    logic [PID_W-1:0]      pid;
    logic [PAGE_W-1:0]     page;
    logic [FRAME_W-1:0]    frame;
    bit                    typed;
    logic                  exp_hit;
    logic [FRAME_W-1:0]    exp_frame;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tfl_req_if in_req ();
  tfl_rsp_if out_rsp ();

  tlb_fifo_lru_lookup #(.TLB_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Model of the entry list: slot 0 is the oldest.
  logic [PID_W-1:0]   held_pid   [DEPTH];
  logic [PAGE_W-1:0]  held_page  [DEPTH];
  logic [FRAME_W-1:0] held_frame [DEPTH];
  int unsigned        held_n = 0;
  logic [MAXE_W-1:0]  set_max = MAX_ENTRIES_RESET;
  logic               set_lru = 1'b0;

  tlb_rsp_t           translations_due [$];
  logic [PID_W-1:0]   tag_pid  [TAG_POOL];
  logic [PAGE_W-1:0]  tag_page [TAG_POOL];
  int                 errors = 0;
  int                 rsp_seen = 0;
  int                 quiet = 0;
  bit                 steady = 1'b0;

  step_row_t directed_plan [N_DIRECTED] = '{
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b1, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_INSERT, 16'hFFFF, 20'hFFFFF, 20'hFFFFF,
      1'b1, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_INSERT, 16'h0000, 20'h00000, 20'h00000,
      1'b1, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000,
      1'b1, 1'b1, 20'hFFFFF},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h0000, 20'h00000, 20'hFFFFF,
      1'b1, 1'b1, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'hFFFF, 20'hFFFFE, 20'h00000,
      1'b1, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'hFFFE, 20'hFFFFF, 20'h00000,
      1'b1, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_INSERT, 16'hFFFF, 20'hFFFFF, 20'h12345,
      1'b1, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000,
      1'b1, 1'b1, 20'hFFFFF},
    '{ROW_CFG, CFG_MAX_ENTRIES, 5'd2, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_CFG, CFG_POLICY_LRU, 5'd1, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_INSERT, 16'h1234, 20'h00005, 20'hABCDE,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h1234, 20'h00005, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_INSERT, 16'h0007, 20'h00007, 20'h00077,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h1234, 20'h00005, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_CFG, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_INSERT, 16'h0009, 20'h00009, 20'h00009,
      1'b1, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b1, 1'b0, 20'h00000},
    '{ROW_CFG, CFG_MAX_ENTRIES, 5'd31, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_CFG, CFG_POLICY_LRU, 5'd0, CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000,
      1'b0, 1'b0, 20'h00000},
    '{ROW_REQ, CFG_MAX_ENTRIES, 5'd0, CMD_LOOKUP, 16'h0007, 20'h00007, 20'h00000,
      1'b0, 1'b0, 20'h00000}
  };

  logic [MAXE_W-1:0] phase_max [PHASES] = '{5'd16, 5'd16, 5'd4, 5'd0, 5'd31, 5'd1,
                                            5'd17, 5'd8};
  logic              phase_lru [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                            1'b1, 1'b0};

  function automatic void drop_entry(input int unsigned at);
    for (int unsigned i = at; i + 1 < held_n; i++) begin
      held_pid[i]   = held_pid[i + 1];
      held_page[i]  = held_page[i + 1];
      held_frame[i] = held_frame[i + 1];
    end
    held_n--;
  endfunction

  function automatic void append_entry(input logic [PID_W-1:0] pid,
                                       input logic [PAGE_W-1:0] page,
                                       input logic [FRAME_W-1:0] frame);
    if (held_n < DEPTH) begin
      held_pid[held_n]   = pid;
      held_page[held_n]  = page;
      held_frame[held_n] = frame;
      held_n++;
    end
  endfunction

  function automatic void translate_and_update(input tlb_req_t r, output tlb_rsp_t res);
    int unsigned lim;
    res = '0;
    lim = (set_max > DEPTH) ? DEPTH : set_max;
    if (lim == 0) return;
    if (r.cmd == CMD_INSERT) begin
      while (held_n >= lim) drop_entry(0);
      append_entry(r.pid, r.page, r.frame);
      return;
    end
    for (int unsigned i = 0; i < held_n; i++) begin
      if (held_pid[i] == r.pid && held_page[i] == r.page) begin
        res.hit   = 1'b1;
        res.frame = held_frame[i];
        if (set_lru) begin
          drop_entry(i);
          append_entry(r.pid, r.page, res.frame);
        end
        return;
      end
    end
  endfunction

  function automatic tlb_req_t draw_request();
    tlb_req_t    r;
    int unsigned k;
    int unsigned sel;
    k = $urandom_range(TAG_POOL - 1);
    sel = $urandom_range(99);
    r.cmd = ($urandom_range(99) < 40) ? CMD_INSERT : CMD_LOOKUP;
    r.frame = FRAME_W'($urandom());
    r.pid = tag_pid[k];
    r.page = tag_page[k];
    if (sel >= 90) begin
      r.pid  = PID_W'($urandom());
      r.page = PAGE_W'($urandom());
    end else if (sel >= 80) begin
      r.page = r.page ^ (PAGE_W'(1) << $urandom_range(PAGE_W - 1));
    end else if (sel >= 75) begin
      r.pid = r.pid ^ (PID_W'(1) << $urandom_range(PID_W - 1));
    end
    return r;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("ERROR response %0d: %s is %h, expected %h", rsp_seen, what, got, want);
    errors++;
  endtask

  task automatic offer_request(input tlb_req_t r, input bit typed, input tlb_rsp_t want);
    tlb_rsp_t predicted;
    in_req.valid <= 1'b1;
    in_req.cmd   <= r.cmd;
    in_req.pid   <= r.pid;
    in_req.page  <= r.page;
    in_req.frame <= r.frame;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    translate_and_update(r, predicted);
    translations_due.push_back(typed ? want : predicted);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    in_req.valid <= 1'b0;
    while (translations_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ENTRIES) set_max = val;
    else set_lru = val[0];
  endtask

  task automatic take_response();
    tlb_rsp_t want;
    rsp_seen++;
    if (translations_due.size() == 0) begin
      flag_error("unrequested response, hit", 32'(out_rsp.hit), 32'h0);
    end else begin
      want = translations_due.pop_front();
      if (out_rsp.hit !== want.hit) flag_error("hit", 32'(out_rsp.hit), 32'(want.hit));
      if (out_rsp.hit_frame !== want.frame)
        flag_error("hit_frame", 32'(out_rsp.hit_frame), 32'(want.frame));
    end
  endtask

  initial begin : response_side
    int hold_left;
    bit held_off;
    hold_left = 0;
    held_off = 1'b0;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_rsp.valid && out_rsp.ready) take_response();
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else if (!held_off && rsp_seen >= HOLD_AT) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tlb_fifo_lru_lookup: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : request_side
    tlb_req_t r;
    tlb_rsp_t want;
    int       issued;
    issued = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_MAX_ENTRIES;
    cfg_wdata    <= '0;
    in_req.valid <= 1'b0;
    in_req.cmd   <= CMD_LOOKUP;
    in_req.pid   <= '0;
    in_req.page  <= '0;
    in_req.frame <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_register(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        r = '{directed_plan[i].cmd, directed_plan[i].pid, directed_plan[i].page,
              directed_plan[i].frame};
        want = '{directed_plan[i].exp_hit, directed_plan[i].exp_frame};
        offer_request(r, directed_plan[i].typed, want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_register(CFG_MAX_ENTRIES,
                     (p == PHASES - 1) ? CFG_DATA_W'($urandom_range(31)) : phase_max[p]);
      write_register(CFG_POLICY_LRU, CFG_DATA_W'(phase_lru[p]));
      foreach (tag_pid[k]) begin
        tag_pid[k]  = PID_W'($urandom());
        tag_page[k] = PAGE_W'($urandom());
      end
      for (int n = 0; n < PHASE_REQS; n++) begin
        steady = (issued >= STEADY_FROM) && (issued < STEADY_TO);
        offer_request(draw_request(), 1'b0, '0);
        issued++;
      end
    end
    steady = 1'b0;
    in_req.valid <= 1'b0;

    while (translations_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tlb_fifo_lru_lookup: match");
    end else begin
      $display("tlb_fifo_lru_lookup: mismatch");
    end
    $finish;
  end

endmodule
